>>> hw/rtl/bup_pkg.sv
// Shared constants and types for the bit unpack and baseline compare core.
package bup_pkg;

	// Packed stream word and output packing
	localparam int WORD_BITS      = 64;
	localparam int POS_BITS       = 6;
	localparam int RAW_BITS       = 32;
	localparam int INDEX_BITS     = 32;
	localparam int VALUE_BITS     = 64;
	localparam int OUT_TDATA_BITS = 104;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_WIDTH  = 32;
	localparam int DEF_COUNT_BITS = 32;

	// Word queue between front and back
	localparam int Q_DEPTH     = 2;
	localparam int Q_PTR_BITS  = 1;
	localparam int Q_CNT_BITS  = 2;

	// Configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 64;

	localparam logic [CFG_IDX_BITS-1:0] REG_BIT_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SKIP_BITS     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ELEMENT_COUNT = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_BASELINE      = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIDE_OUTPUT   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_COMPARE_VALUE = 3'd5;

	// One unpacked element on its way to the output stage
	typedef struct packed {
		logic [RAW_BITS-1:0]   raw;
		logic [INDEX_BITS-1:0] index;
		logic                  last;
	} elem_t;

	// Queue status seen by the back part
	typedef struct packed {
		logic head_valid;
		logic full;
	} q_st_t;

endpackage

>>> hw/rtl/bup_front.sv
// Front part: accepts words, drops them while the run count is zero, queues the rest.
module bup_front
	import bup_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [WORD_BITS-1:0] s_tdata,    // [63:0] packed_word
	input  logic                 cnt_zero,
	input  logic                 pop,
	output q_st_t                q_st,
	output logic [WORD_BITS-1:0] head_word
);

	logic [WORD_BITS-1:0]  mem_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0] wr_ptr_q;
	logic [Q_PTR_BITS-1:0] rd_ptr_q;
	logic [Q_CNT_BITS-1:0] cnt_q;
	logic                  push;

	// Classify the beat: keep it only while a run is configured
	assign s_tready = (cnt_q != Q_CNT_BITS'(Q_DEPTH));
	assign push     = s_tvalid && s_tready && !cnt_zero;

	assign q_st.head_valid = (cnt_q != '0);
	assign q_st.full       = !s_tready;
	assign head_word       = mem_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store the word
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= s_tdata;
		end
	end

endmodule

>>> hw/rtl/bup_unpack.sv
// Back part: cuts one element per cycle from the word unless stalled, carries tail bits.
module bup_unpack
	import bup_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int COUNT_BITS = DEF_COUNT_BITS,
	localparam int WB = $clog2(MAX_WIDTH + 1),
	localparam int CB = $clog2(MAX_WIDTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [WB-1:0]         width,
	input  logic [POS_BITS-1:0]   skip,
	input  logic [COUNT_BITS-1:0] cnt,
	input  logic                  rearm,
	input  q_st_t                 q_st,
	input  logic [WORD_BITS-1:0]  head_word,
	output logic                  pop,
	input  logic                  take,
	output logic                  vld_s1,
	output elem_t                 el_s1
);

	logic [WORD_BITS-1:0]  word_q;
	logic                  busy_q;
	logic [POS_BITS-1:0]   pos_q;
	logic [MAX_WIDTH-1:0]  carry_q;
	logic [CB-1:0]         ccnt_q;
	logic [COUNT_BITS-1:0] emitted_q;
	logic                  first_q;

	logic [WORD_BITS-1:0]  word_n;
	logic                  busy_n;
	logic [POS_BITS-1:0]   pos_n;
	logic [MAX_WIDTH-1:0]  carry_n;
	logic [CB-1:0]         ccnt_n;
	logic [COUNT_BITS-1:0] emitted_n;
	logic                  first_n;

	logic                  s1_free;
	logic                  step;
	logic [WORD_BITS-1:0]  shifted;
	logic [WORD_BITS-1:0]  rest;
	logic [WB-1:0]         need;
	logic [MAX_WIDTH-1:0]  mask;
	logic [MAX_WIDTH-1:0]  raw;
	logic [POS_BITS:0]     pos_nx;
	logic [POS_BITS:0]     left;
	logic [POS_BITS:0]     head_left;
	logic                  last;
	logic                  finish;

	// Extract the next element
	assign s1_free   = !vld_s1 || take;
	assign step      = busy_q && s1_free;
	assign shifted   = word_q >> pos_q;
	assign need      = width - WB'(ccnt_q);
	assign mask      = {MAX_WIDTH{1'b1}} >> (WB'(MAX_WIDTH) - width);
	assign raw       = (carry_q | (shifted[MAX_WIDTH-1:0] << ccnt_q)) & mask;
	assign pos_nx    = {1'b0, pos_q} + (POS_BITS+1)'(need);
	assign left      = (POS_BITS+1)'(WORD_BITS) - pos_nx;
	assign rest      = word_q >> pos_nx;
	assign last      = ({1'b0, emitted_q} + 1'b1) >= {1'b0, cnt};
	assign finish    = last || (left < (POS_BITS+1)'(width));
	assign head_left = (POS_BITS+1)'(WORD_BITS) - {1'b0, skip};

	// Next state: step the current word, then load the next one; a rearm stops the run
	always_comb begin
		word_n    = word_q;
		busy_n    = busy_q;
		pos_n     = pos_q;
		carry_n   = carry_q;
		ccnt_n    = ccnt_q;
		emitted_n = emitted_q;
		first_n   = first_q;
		pop       = 1'b0;

		if (step) begin
			emitted_n = emitted_q + 1'b1;
			carry_n   = '0;
			ccnt_n    = '0;
			if (last) begin
				// Run complete: drop the rest of the word and rearm
				emitted_n = '0;
				first_n   = 1'b1;
				busy_n    = 1'b0;
			end else if (finish) begin
				// Hold the tail bits for the next word
				carry_n = MAX_WIDTH'(rest);
				ccnt_n  = CB'(left);
				busy_n  = 1'b0;
			end else begin
				pos_n = pos_nx[POS_BITS-1:0];
			end
		end

		if (!busy_n && q_st.head_valid) begin
			pop    = 1'b1;
			busy_n = 1'b1;
			word_n = head_word;
			if (first_n) begin
				pos_n   = skip;
				carry_n = '0;
				ccnt_n  = '0;
				first_n = 1'b0;
				// No element fits after the skip: carry the whole tail
				if (head_left < (POS_BITS+1)'(width)) begin
					busy_n  = 1'b0;
					carry_n = MAX_WIDTH'(head_word >> skip);
					ccnt_n  = CB'(head_left);
				end
			end else begin
				pos_n = '0;
			end
		end

		if (rearm) begin
			pop       = 1'b0;
			busy_n    = 1'b0;
			carry_n   = '0;
			ccnt_n    = '0;
			emitted_n = '0;
			first_n   = 1'b1;
		end
	end

	// Control state and stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			pos_q     <= '0;
			carry_q   <= '0;
			ccnt_q    <= '0;
			emitted_q <= '0;
			first_q   <= 1'b1;
			vld_s1    <= 1'b0;
		end else begin
			busy_q    <= busy_n;
			pos_q     <= pos_n;
			carry_q   <= carry_n;
			ccnt_q    <= ccnt_n;
			emitted_q <= emitted_n;
			first_q   <= first_n;
			if (s1_free) begin
				vld_s1 <= step;
			end
		end
	end

	// Word and element payload
	always_ff @(posedge clk) begin
		word_q <= word_n;
		if (step) begin
			el_s1.raw   <= RAW_BITS'(raw);
			el_s1.index <= INDEX_BITS'(emitted_q);
			el_s1.last  <= last;
		end
	end

endmodule

>>> hw/rtl/bup_emit.sv
// Output stage: adds the baseline, compares the raw element and holds the result beat.
module bup_emit
	import bup_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      vld_s1,
	input  elem_t                     el_s1,
	output logic                      take,
	input  logic [VALUE_BITS-1:0]     baseline,
	input  logic                      wide,
	input  logic [RAW_BITS-1:0]       compare,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_TDATA_BITS-1:0] m_tdata,    // [63:0] element_value, [95:64] element_index,
	                                               // [96] equal_flag, [103:97] zero
	output logic                      m_tlast      // last_flag
);

	logic [VALUE_BITS-1:0] sum;
	logic [VALUE_BITS-1:0] value;
	logic                  equal;

	// Add baseline and wrap per width mode
	assign sum   = VALUE_BITS'(el_s1.raw) + baseline;
	assign value = wide ? sum : {32'b0, sum[31:0]};
	assign equal = (el_s1.raw == compare);
	assign take  = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (take) begin
			m_tvalid <= vld_s1;
		end
	end

	// Load the result beat
	always_ff @(posedge clk) begin
		if (take && vld_s1) begin
			m_tdata <= {(OUT_TDATA_BITS-VALUE_BITS-INDEX_BITS-1)'(0), equal, el_s1.index, value};
			m_tlast <= el_s1.last;
		end
	end

endmodule

>>> hw/rtl/bit_unpack_baseline_compare_core.sv
// Top level of the bit unpack and baseline compare core.
//
//   channel  direction  handshake          payload
//   s_       in         s_tvalid/s_tready  s_tdata[63:0] packed_word
//   m_       out        m_tvalid/m_tready  m_tdata element_value/index/equal, m_tlast
//   cfg_     in         cfg_we             cfg_index, cfg_data
//
// One element leaves per cycle while the output takes beats and a word is ready; the
// single extract step in bup_unpack sets that rate. A word passes through the queue,
// the word register in bup_unpack, the element stage and the output register.
// A two-word queue lets words arrive while results stall. Reset clears the control state,
// not the stored words and payloads, and sets the width to one; a width write rearms the run.
module bit_unpack_baseline_compare_core
	import bup_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [WORD_BITS-1:0]      s_tdata,    // [63:0] packed_word
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_TDATA_BITS-1:0] m_tdata,    // [63:0] element_value, [95:64] element_index,
	                                               // [96] equal_flag, [103:97] zero
	output logic                      m_tlast,    // last_flag
	input  logic                      cfg_we,
	input  logic [CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int WB = $clog2(MAX_WIDTH + 1);

	logic [5:0]            bit_width_q;
	logic [POS_BITS-1:0]   skip_q;
	logic [31:0]           count_q;
	logic [VALUE_BITS-1:0] baseline_q;
	logic                  wide_q;
	logic [31:0]           compare_q;

	logic [WB-1:0]         width;
	logic [COUNT_BITS-1:0] cnt;
	logic                  cnt_zero;
	logic                  rearm;
	q_st_t                 q_st;
	logic [WORD_BITS-1:0]  head_word;
	logic                  pop;
	logic                  take;
	logic                  vld_s1;
	elem_t                 el_s1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_width_q <= 6'd1;
			skip_q      <= '0;
			count_q     <= '0;
			baseline_q  <= '0;
			wide_q      <= 1'b0;
			compare_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BIT_WIDTH:     bit_width_q <= cfg_data[5:0];
				REG_SKIP_BITS:     skip_q      <= cfg_data[POS_BITS-1:0];
				REG_ELEMENT_COUNT: count_q     <= cfg_data[31:0];
				REG_BASELINE:      baseline_q  <= cfg_data;
				REG_WIDE_OUTPUT:   wide_q      <= cfg_data[0];
				REG_COMPARE_VALUE: compare_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Clamp width and mask count
	always_comb begin
		if (bit_width_q == 6'd0) begin
			width = WB'(1);
		end else if (bit_width_q > 6'(MAX_WIDTH)) begin
			width = WB'(MAX_WIDTH);
		end else begin
			width = WB'(bit_width_q);
		end
	end

	assign cnt      = COUNT_BITS'(count_q);
	assign cnt_zero = (cnt == '0);
	assign rearm    = cfg_we && (cfg_index == REG_BIT_WIDTH);

	bup_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cnt_zero  (cnt_zero),
		.pop       (pop),
		.q_st      (q_st),
		.head_word (head_word)
	);

	bup_unpack #(
		.MAX_WIDTH  (MAX_WIDTH),
		.COUNT_BITS (COUNT_BITS)
	) u_unpack (
		.clk       (clk),
		.arst_n    (arst_n),
		.width     (width),
		.skip      (skip_q),
		.cnt       (cnt),
		.rearm     (rearm),
		.q_st      (q_st),
		.head_word (head_word),
		.pop       (pop),
		.take      (take),
		.vld_s1    (vld_s1),
		.el_s1     (el_s1)
	);

	bup_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_s1   (vld_s1),
		.el_s1    (el_s1),
		.take     (take),
		.baseline (baseline_q),
		.wide     (wide_q),
		.compare  (compare_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTHESIS
	// The back part only takes a word that the queue holds
	a_pop_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_st.head_valid)
		else $error("word taken from empty queue");

	// No word is queued while no run is configured
	a_zero_count_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_zero |-> !q_st.head_valid)
		else $error("word queued with zero element count");

	// A pending element stays until the output stage takes it
	a_elem_held: assert property (@(posedge clk) disable iff (!arst_n || rearm)
		vld_s1 && !take |=> vld_s1 && $stable(el_s1))
		else $error("pending element lost");
`endif

endmodule

>>> verif/bit_unpack_baseline_compare_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the bit unpack and baseline compare core.
module bit_unpack_baseline_compare_core_test;
	import bup_pkg::*;

	localparam int LIMIT_CYCLES  = 600000;
	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD     = 400;

	// Index with no register behind it; a write there must change nothing
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

	// One unpacked element as it leaves the block
	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [INDEX_BITS-1:0] index;
		logic                  equal;
		logic                  last;
	} elem_beat_t;

	// One row of stimulus: a register write or a packed word
	typedef struct {
		bit                       is_reg;
		logic [CFG_IDX_BITS-1:0]  reg_index;
		logic [CFG_DATA_BITS-1:0] data;
		bit                       typed;
		int                       typed_n;
		elem_beat_t [2:0]         typed_beats;
	} stim_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [WORD_BITS-1:0]      s_tdata = '0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_tdata;
	logic                      m_tlast;
	logic                      cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	bit_unpack_baseline_compare_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock: 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor copy of the registers and the unpack state
	logic [5:0]  width_reg;
	logic [5:0]  skip_reg;
	logic [31:0] count_reg;
	logic [63:0] base_reg;
	logic        wide_reg;
	logic [31:0] cmp_reg;
	logic [31:0] carry_bits;
	int          carry_count;
	logic [31:0] emitted;
	bit          first_pending;

	elem_beat_t pending_elems[$];
	elem_beat_t want;
	stim_row_t  dir_tab[$];

	int  errors = 0;
	int  words_sent = 0;
	int  beats_seen = 0;
	int  reg_writes = 0;
	int  cycle_count = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  hold_left = 0;
	bit  hold_req = 1'b0;
	bit  stream_busy = 1'b0;

	function automatic void rearm_run();
		carry_bits = '0;
		carry_count = 0;
		emitted = '0;
		first_pending = 1'b1;
	endfunction

	function automatic int cur_width();
		if (width_reg == 0) return 1;
		if (width_reg > 32) return 32;
		return int'(width_reg);
	endfunction

	// Update the predictor registers on a write
	function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] data);
		case (idx)
			REG_BIT_WIDTH: begin
				width_reg = data[5:0];
				rearm_run();
			end
			REG_SKIP_BITS:     skip_reg = data[5:0];
			REG_ELEMENT_COUNT: count_reg = data[31:0];
			REG_BASELINE:      base_reg = data;
			REG_WIDE_OUTPUT:   wide_reg = data[0];
			REG_COMPARE_VALUE: cmp_reg = data[31:0];
			default: ;
		endcase
	endfunction

	// Unpack one accepted word and queue the elements it completes
	task automatic unpack_word(input logic [63:0] word, input bit keep);
		int w;
		int pos;
		int need;
		int left;
		int n;
		logic [63:0] bits;
		logic [63:0] raw;
		logic [63:0] sum;
		bit last_elem;
		elem_beat_t beat;
		w = cur_width();
		pos = 0;
		n = 0;
		if (count_reg == 0) return;
		if (first_pending) begin
			pos = int'(skip_reg);
			carry_bits = '0;
			carry_count = 0;
			first_pending = 1'b0;
		end
		while ((64 - pos) + carry_count >= w && n < 64) begin
			need = w - carry_count;
			bits = (word >> pos) & ((64'd1 << need) - 64'd1);
			raw = ({32'd0, carry_bits} | (bits << carry_count)) & ((64'd1 << w) - 64'd1);
			sum = raw + base_reg;
			pos += need;
			carry_bits = '0;
			carry_count = 0;
			if (!wide_reg) sum[63:32] = '0;
			last_elem = ({32'd0, emitted} + 64'd1) >= {32'd0, count_reg};
			beat.value = sum;
			beat.index = emitted;
			beat.equal = (raw == {32'd0, cmp_reg});
			beat.last = last_elem;
			if (keep) pending_elems.push_back(beat);
			n++;
			emitted = emitted + 32'd1;
			if (last_elem) begin
				rearm_run();
				return;
			end
			if (pos >= 64) break;
		end
		// Carry the tail of the word into the next one
		if (pos < 64) begin
			left = 64 - pos;
			carry_bits = 32'((word >> pos) & ((64'd1 << left) - 64'd1));
			carry_count = left;
		end
	endtask

	function automatic elem_beat_t beat_of(logic [63:0] v, logic [31:0] idx, logic eq, logic lst);
		elem_beat_t b;
		b.value = v;
		b.index = idx;
		b.equal = eq;
		b.last = lst;
		return b;
	endfunction

	function automatic stim_row_t reg_row(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] data);
		stim_row_t r;
		r.is_reg = 1'b1;
		r.reg_index = idx;
		r.data = data;
		r.typed = 1'b0;
		r.typed_n = 0;
		r.typed_beats = '0;
		return r;
	endfunction

	function automatic stim_row_t word_row(logic [63:0] data);
		stim_row_t r;
		r = reg_row(REG_BIT_WIDTH, data);
		r.is_reg = 1'b0;
		return r;
	endfunction

	function automatic stim_row_t typed_row(logic [63:0] data, int n,
			elem_beat_t b0, elem_beat_t b1, elem_beat_t b2);
		stim_row_t r;
		r = word_row(data);
		r.typed = 1'b1;
		r.typed_n = n;
		r.typed_beats = {b2, b1, b0};
		return r;
	endfunction

	// Repeat a value at the element width across a word
	function automatic logic [63:0] tile_value(logic [31:0] v, int w);
		logic [63:0] t;
		t = '0;
		for (int b = 0; b < 64; b += w)
			t |= ({32'd0, v} & ((64'd1 << w) - 64'd1)) << b;
		return t;
	endfunction

	// Hold the stream until every queued element has come out
	task automatic drain_stream();
		s_tvalid <= 1'b0;
		while (pending_elems.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		stream_busy = 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [63:0] data);
		if (stream_busy) drain_stream();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		apply_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	// Offer one word, then predict its elements at the accepting edge
	task automatic send_word(input stim_row_t row);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= row.data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (row.typed) begin
			unpack_word(row.data, 1'b0);
			for (int i = 0; i < row.typed_n; i++) pending_elems.push_back(row.typed_beats[i]);
		end else begin
			unpack_word(row.data, 1'b1);
		end
		words_sent++;
		stream_busy = 1'b1;
	endtask

	// Draw a fresh setting; a deep setting keeps the block busy on every word
	task automatic pick_settings(input bit write_all, input bit deep);
		logic [63:0] v;
		int roll;
		int m;
		for (int r = REG_BIT_WIDTH; r <= REG_COMPARE_VALUE; r++) begin
			if (write_all || deep || $urandom_range(99) < 70) begin
				roll = $urandom_range(9);
				v = {$urandom, $urandom};
				case (r)
					REG_BIT_WIDTH: begin
						if (deep) v = 64'($urandom_range(8, 1));
						else if (roll == 0) v = '0;
						else if (roll == 1) v = 64'($urandom_range(63, 33));
						else v = 64'($urandom_range(32, 1));
					end
					REG_SKIP_BITS: begin
						if (roll > 1) v = 64'($urandom_range(63));
					end
					REG_ELEMENT_COUNT: begin
						if (deep || roll == 1) v[31:0] = 32'hFFFF_FFFF;
						else if (roll == 0) v[31:0] = '0;
						else if (roll > 2) v[31:0] = $urandom_range(24, 1);
					end
					REG_BASELINE: begin
						if (roll == 0) v = '0;
						else if (roll == 1) v = '1;
					end
					REG_COMPARE_VALUE: begin
						m = cur_width();
						if (roll < 4) v[31:0] = '0;
						else if (roll < 6) v[31:0] = 32'((64'd1 << m) - 64'd1);
						else if (roll < 9) v[31:0] = 32'(v[31:0] & ((64'd1 << m) - 64'd1));
					end
					default: ;
				endcase
				write_reg(3'(r), v);
			end
		end
	endtask

	function automatic logic [63:0] random_word();
		int roll;
		roll = $urandom_range(99);
		if (roll < 15) return '0;
		if (roll < 25) return '1;
		if (roll < 40) return tile_value(cmp_reg, cur_width());
		return {$urandom, $urandom};
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
		end
	endtask

	// Receiver: random ready, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each output beat with the oldest queued element; bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_elems.size() == 0) begin
				errors++;
				$display("%0t: beat with no element waiting, expected none, actual %h last %b",
					$time, m_tdata, m_tlast);
			end else begin
				want = pending_elems.pop_front();
				check_field("element_value", want.value, m_tdata[63:0]);
				check_field("element_index", {32'd0, want.index}, {32'd0, m_tdata[95:64]});
				check_field("equal_flag", {63'd0, want.equal}, {63'd0, m_tdata[96]});
				check_field("last_flag", {63'd0, want.last}, {63'd0, m_tlast});
				check_field("tdata padding", '0, {57'd0, m_tdata[103:97]});
				beats_seen++;
			end
		end
	end

	initial begin
		width_reg = 6'd1;
		skip_reg = '0;
		count_reg = '0;
		base_reg = '0;
		wide_reg = 1'b0;
		cmp_reg = '0;
		rearm_run();

		// Directed table: after reset the count is zero, so the first word is ignored
		dir_tab.push_back(typed_row('1, 0, '0, '0, '0));
		dir_tab.push_back(reg_row(REG_ELEMENT_COUNT, 64'd1));
		dir_tab.push_back(typed_row(64'h1, 1, beat_of(64'd1, 0, 1'b0, 1'b1), '0, '0));
		dir_tab.push_back(typed_row(64'h0, 1, beat_of(64'd0, 0, 1'b1, 1'b1), '0, '0));
		// Full width, all-ones data and compare
		dir_tab.push_back(reg_row(REG_BIT_WIDTH, 64'd32));
		dir_tab.push_back(reg_row(REG_ELEMENT_COUNT, 64'd2));
		dir_tab.push_back(reg_row(REG_COMPARE_VALUE, 64'hFFFF_FFFF));
		dir_tab.push_back(typed_row('1, 2, beat_of(64'hFFFF_FFFF, 0, 1'b1, 1'b0),
			beat_of(64'hFFFF_FFFF, 1, 1'b1, 1'b1), '0));
		// Largest skip, baseline and count with 64-bit sums: elements span words
		dir_tab.push_back(reg_row(REG_BASELINE, '1));
		dir_tab.push_back(reg_row(REG_WIDE_OUTPUT, 64'd1));
		dir_tab.push_back(reg_row(REG_ELEMENT_COUNT, 64'hFFFF_FFFF));
		dir_tab.push_back(reg_row(REG_SKIP_BITS, 64'd63));
		dir_tab.push_back(word_row('1));
		dir_tab.push_back(word_row(64'h0123_4567_89AB_CDEF));
		dir_tab.push_back(word_row(64'hFEDC_BA98_7654_3210));
		// Zero width acts as one; 32-bit wrap of the sum
		dir_tab.push_back(reg_row(REG_BIT_WIDTH, 64'd0));
		dir_tab.push_back(reg_row(REG_SKIP_BITS, 64'd0));
		dir_tab.push_back(reg_row(REG_ELEMENT_COUNT, 64'd3));
		dir_tab.push_back(reg_row(REG_WIDE_OUTPUT, 64'd0));
		dir_tab.push_back(reg_row(REG_COMPARE_VALUE, 64'd1));
		dir_tab.push_back(typed_row(64'h5, 3, beat_of(64'd0, 0, 1'b1, 1'b0),
			beat_of(64'hFFFF_FFFF, 1, 1'b0, 1'b0), beat_of(64'd0, 2, 1'b1, 1'b1)));
		// Oversized width acts as the maximum, with a mid-word start
		dir_tab.push_back(reg_row(REG_BIT_WIDTH, 64'd63));
		dir_tab.push_back(reg_row(REG_SKIP_BITS, 64'd16));
		dir_tab.push_back(reg_row(REG_ELEMENT_COUNT, 64'd2));
		dir_tab.push_back(reg_row(REG_BASELINE, 64'd0));
		dir_tab.push_back(reg_row(REG_COMPARE_VALUE, 64'd5));
		dir_tab.push_back(word_row(64'h89AB_CDEF_0123_4567));
		dir_tab.push_back(word_row(64'h0000_0000_0000_0005));
		// Compare value wider than the element never matches; tail of word dropped
		dir_tab.push_back(reg_row(REG_BIT_WIDTH, 64'd4));
		dir_tab.push_back(reg_row(REG_SKIP_BITS, 64'd0));
		dir_tab.push_back(reg_row(REG_ELEMENT_COUNT, 64'd20));
		dir_tab.push_back(reg_row(REG_COMPARE_VALUE, 64'h1F));
		dir_tab.push_back(word_row('1));
		dir_tab.push_back(word_row(64'h1111_1111_1111_1111));
		// Count lowered below the elements already out ends the run at once
		dir_tab.push_back(reg_row(REG_BIT_WIDTH, 64'd8));
		dir_tab.push_back(reg_row(REG_ELEMENT_COUNT, 64'd10));
		dir_tab.push_back(reg_row(REG_COMPARE_VALUE, 64'h80));
		dir_tab.push_back(word_row(64'h8001_0203_FF7F_0080));
		dir_tab.push_back(reg_row(REG_ELEMENT_COUNT, 64'd3));
		dir_tab.push_back(word_row(64'h0000_0000_0000_0042));
		dir_tab.push_back(reg_row(REG_UNUSED, '1));
		dir_tab.push_back(word_row(64'h0102_0304_0506_0708));
		// Width above the range, junk above the skip field
		dir_tab.push_back(reg_row(REG_BIT_WIDTH, 64'd33));
		dir_tab.push_back(reg_row(REG_ELEMENT_COUNT, 64'd1));
		dir_tab.push_back(reg_row(REG_SKIP_BITS, 64'hFFFF_FFFF_FFFF_FFC0));
		dir_tab.push_back(typed_row('1, 1, beat_of(64'hFFFF_FFFF, 0, 1'b0, 1'b1), '0, '0));
		// 64-bit sum that wraps to zero
		dir_tab.push_back(reg_row(REG_BIT_WIDTH, 64'd32));
		dir_tab.push_back(reg_row(REG_WIDE_OUTPUT, 64'd1));
		dir_tab.push_back(reg_row(REG_BASELINE, 64'hFFFF_FFFF_0000_0001));
		dir_tab.push_back(typed_row(64'h0000_0000_FFFF_FFFF, 1,
			beat_of(64'd0, 0, 1'b0, 1'b1), '0, '0));

		// Reset
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 18;
		recv_idle_pct = 68;
		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_reg) write_reg(dir_tab[i].reg_index, dir_tab[i].data);
			else send_word(dir_tab[i]);
		end

		// Random runs in three idling phases
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 68 : 0;
			recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 18 : 0;
			for (int run = 0; run < 4; run++) begin
				pick_settings(run == 0, phase == 2 && run == 0);
				// Stall the output while words keep coming, so the input backs up
				if (phase == 2 && run == 0) hold_req = 1'b1;
				for (int k = $urandom_range(11, 5); k > 0; k--) send_word(word_row(random_word()));
				if (run == 1) drain_stream();
			end
		end
		drain_stream();

		$display("Ran %0d words, %0d element beats, %0d register writes.",
			words_sent, beats_seen, reg_writes);
		$display("Covered widths 1-32 and out of range, skips, carries, 32/64-bit sums, rearm.");
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
